### sv/efr_pkg.sv
// shared constants, codes and crc helper for the escaped frame receiver
`default_nettype none

package efr_pkg;

    localparam logic [7:0]  MARK_START  = 8'h01;
    localparam logic [7:0]  MARK_END    = 8'h04;
    localparam logic [7:0]  MARK_ESCAPE = 8'h10;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam int unsigned CRC_BYTES   = 4;

    localparam logic [1:0] ACT_BYTE     = 2'd0;
    localparam logic [1:0] ACT_LINE_ERR = 2'd1;
    localparam logic [1:0] ACT_READ     = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CRC  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_READ     = 2'd3;

    typedef logic [1:0] t_status;

    // one byte of reflected crc-32, bitwise
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/efr_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module efr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4105
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### sv/efr_frame.sv
// deframing control, crc state, store access and first result stage
`default_nettype none

module efr_frame #(
    parameter int BLOCK_BYTES = 4096
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_accept,
    input  wire logic [1:0]                           i_action,
    input  wire logic [7:0]                           i_rx_byte,
    input  wire logic [$clog2(BLOCK_BYTES+10)-1:0]    i_read_index,
    input  wire logic                                 i_s1_move,
    output logic                                      o_s1_valid,
    output efr_pkg::t_status                          o_s1_status,
    output logic      [$clog2(BLOCK_BYTES+10)-1:0]    o_s1_length,
    output logic      [7:0]                           o_s1_read_byte
);

    import efr_pkg::*;

    localparam int STORE_DEPTH = BLOCK_BYTES + 9;
    localparam int CNT_W       = $clog2(BLOCK_BYTES + 10);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);
    localparam logic [CNT_W-1:0] CRCB_C  = CNT_W'(CRC_BYTES);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_esc, n_esc;
    logic [31:0]      r_crc, n_crc;
    logic [31:0]      r_last4, n_last4;

    logic             r_s1_valid, n_s1_valid;
    t_status          r_s1_status, n_s1_status;
    logic [CNT_W-1:0] r_s1_length, n_s1_length;
    logic             r_s1_rd, n_s1_rd;

    logic             we, re;
    logic [7:0]       rdata;

    always_comb begin
        n_count     = r_count;
        n_esc       = r_esc;
        n_crc       = r_crc;
        n_last4     = r_last4;
        n_s1_valid  = r_s1_valid && !i_s1_move;
        n_s1_status = r_s1_status;
        n_s1_length = r_s1_length;
        n_s1_rd     = r_s1_rd;
        we          = 1'b0;
        re          = 1'b0;
        if (i_accept) begin
            unique case (i_action)
                ACT_LINE_ERR: begin
                    n_count = '0;
                    n_crc   = CRC_INIT;
                    n_last4 = '0;
                end
                ACT_READ: begin
                    re          = 1'b1;
                    n_s1_valid  = 1'b1;
                    n_s1_status = ST_READ;
                    n_s1_length = '0;
                    n_s1_rd     = i_read_index < DEPTH_C;
                end
                ACT_BYTE: begin
                    if (!r_esc && i_rx_byte == MARK_START) begin
                        n_count = '0;
                        n_crc   = CRC_INIT;
                        n_last4 = '0;
                        n_esc   = 1'b0;
                    end else if (!r_esc && i_rx_byte == MARK_ESCAPE) begin
                        n_esc = 1'b1;
                    end else if (!r_esc && i_rx_byte == MARK_END) begin
                        if (r_count > CRCB_C) begin
                            n_s1_valid  = 1'b1;
                            n_s1_status = ((r_crc ^ CRC_INIT) == r_last4) ? ST_OK : ST_BAD_CRC;
                            n_s1_length = r_count - CRCB_C;
                            n_s1_rd     = 1'b0;
                            n_count     = '0;
                            n_crc       = CRC_INIT;
                            n_last4     = '0;
                            n_esc       = 1'b0;
                        end
                    end else if (r_count >= DEPTH_C) begin
                        n_s1_valid  = 1'b1;
                        n_s1_status = ST_OVERFLOW;
                        n_s1_length = '0;
                        n_s1_rd     = 1'b0;
                        n_count     = '0;
                        n_crc       = CRC_INIT;
                        n_last4     = '0;
                        n_esc       = 1'b0;
                    end else begin
                        we = 1'b1;
                        if (r_count >= CRCB_C) begin
                            n_crc = crc_byte(r_crc, r_last4[7:0]);
                        end
                        n_last4 = {i_rx_byte, r_last4[31:8]};
                        n_count = r_count + ONE_C;
                        n_esc   = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_esc      <= 1'b0;
            r_crc      <= CRC_INIT;
            r_last4    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_esc      <= n_esc;
            r_crc      <= n_crc;
            r_last4    <= n_last4;
            r_s1_valid <= n_s1_valid;
        end
        r_s1_status <= n_s1_status;
        r_s1_length <= n_s1_length;
        r_s1_rd     <= n_s1_rd;
    end

    efr_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_count[ADDR_W-1:0]),
        .i_wdata(i_rx_byte),
        .i_re   (re),
        .i_raddr(i_read_index[ADDR_W-1:0]),
        .o_rdata(rdata)
    );

    assign o_s1_valid     = r_s1_valid;
    assign o_s1_status    = r_s1_status;
    assign o_s1_length    = r_s1_length;
    assign o_s1_read_byte = r_s1_rd ? rdata : 8'd0;

endmodule

`default_nettype wire

### sv/efr_outq.sv
// output register with skid entry, ready taken from a register
`default_nettype none

module efr_outq #(
    parameter int W = 23
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s1_valid,
    input  wire logic [W-1:0] i_s1_data,
    output logic              o_s1_move,
    output logic              o_in_ready,
    output logic              o_valid,
    output logic      [W-1:0] o_data,
    input  wire logic         i_ready
);

    logic         r_out_valid, n_out_valid;
    logic [W-1:0] r_out_data, n_out_data;
    logic         r_skid_valid, n_skid_valid;
    logic [W-1:0] r_skid_data, n_skid_data;
    logic         out_load;

    always_comb begin
        out_load     = !r_out_valid || i_ready;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (out_load) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = i_s1_valid;
                n_skid_data  = i_s1_data;
            end else begin
                n_out_valid = i_s1_valid;
                n_out_data  = i_s1_data;
            end
        end else if (!r_skid_valid) begin
            n_skid_valid = i_s1_valid;
            n_skid_data  = i_s1_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_s1_move  = out_load || !r_skid_valid;
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out_data;

endmodule

`default_nettype wire

### sv/escaped_frame_receiver_crc32_unit.sv
// top level of the escaped frame receiver with crc-32 check
`default_nettype none

// Takes one item per clock while i_ready is high: a line byte, a line error
// or a read of the frame store. Bytes are unescaped and written into a
// single-port-write store of BLOCK_BYTES+9 bytes while a reflected crc-32
// runs over all but the newest four; an unescaped end byte after more than
// four bytes reports ok or crc mismatch with the payload length, and a byte
// beyond a full store reports overflow. Each item is taken at its accept
// edge: the store is written or read there and all frame state updates in
// the same cycle, so items may follow back to back. A result is registered
// in the first result stage at the accept edge, where the store read data is
// also loaded, and then in the output register. A skid entry behind the
// output register keeps i_ready registered; it drops only after two results
// wait on a stalled output. The store needs no clearing after reset.
module escaped_frame_receiver_crc32_unit #(
    parameter int BLOCK_BYTES = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   i_ready,
    input  wire logic [1:0]                        i_action,
    input  wire logic [7:0]                        i_rx_byte,
    input  wire logic [$clog2(BLOCK_BYTES+10)-1:0] i_read_index,
    output logic                                   o_valid,
    input  wire logic                              o_ready,
    output efr_pkg::t_status                       o_status,
    output logic      [$clog2(BLOCK_BYTES+10)-1:0] o_payload_length,
    output logic      [7:0]                        o_read_byte
);

    import efr_pkg::*;

    localparam int CNT_W = $clog2(BLOCK_BYTES + 10);
    localparam int RES_W = 2 + CNT_W + 8;

    logic             accept;
    logic             s1_valid, s1_move;
    t_status          s1_status;
    logic [CNT_W-1:0] s1_length;
    logic [7:0]       s1_read_byte;
    logic [RES_W-1:0] out_data;

    assign accept = i_valid && i_ready;

    efr_frame #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_action      (i_action),
        .i_rx_byte     (i_rx_byte),
        .i_read_index  (i_read_index),
        .i_s1_move     (s1_move),
        .o_s1_valid    (s1_valid),
        .o_s1_status   (s1_status),
        .o_s1_length   (s1_length),
        .o_s1_read_byte(s1_read_byte)
    );

    efr_outq #(
        .W(RES_W)
    ) u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1_valid(s1_valid),
        .i_s1_data ({s1_status, s1_length, s1_read_byte}),
        .o_s1_move (s1_move),
        .o_in_ready(i_ready),
        .o_valid   (o_valid),
        .o_data    (out_data),
        .i_ready   (o_ready)
    );

    assign o_status         = out_data[RES_W-1 -: 2];
    assign o_payload_length = out_data[8 +: CNT_W];
    assign o_read_byte      = out_data[7:0];

endmodule

`default_nettype wire
